>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

>>> hw/rtl/gnom_pkg.sv
// Shared constants, types and tables for the observation map.
`default_nettype none
package gnom_pkg;

  localparam int POS_W      = 5;
  localparam int CRD_W      = POS_W + 2;
  localparam int TYPE_W     = 2;
  localparam int NBR        = 9;
  localparam int NBR_IDX_W  = $clog2(NBR);
  localparam int TYPES_W    = NBR * TYPE_W;
  localparam int MAX_TYPES  = 4;
  localparam int CELL_W     = 3;
  localparam int COUNT_W    = 16;
  localparam int MODE_W     = 2;
  localparam int QSEL_W     = 2;

  localparam int DEF_GRID_W        = 16;
  localparam int DEF_GRID_H        = 16;
  localparam int DEF_NUM_QUADRANTS = 4;

  localparam int SQ_LO = 7;
  localparam int SQ_HI = 15;

  localparam logic signed [CELL_W-1:0] CELL_UNSEEN = -3'sd1;
  localparam logic signed [CELL_W-1:0] CELL_WALL   = 3'sd2;
  localparam logic signed [CELL_W-1:0] CELL_FLOOR  = 3'sd0;

  localparam logic [TYPE_W-1:0] TYPES_IN_MODE_THREE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_THREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd2;

  typedef enum logic [1:0] {
    ACT_OBSERVE    = 2'd0,
    ACT_CLEAR      = 2'd1,
    ACT_READ_COUNT = 2'd2,
    ACT_READ_CELL  = 2'd3
  } action_t;

  // Neighbour offsets relative to the agent position (world = agent + 1 + d)
  localparam logic [1:0] NB_OFF_X [NBR] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd2};
  localparam logic [1:0] NB_OFF_Y [NBR] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0,
                                            2'd0, 2'd1, 2'd2};

  typedef struct packed {
    logic              in_map;
    logic              border;
    logic [1:0]        quad;
    logic [TYPE_W-1:0] ctype;
  } lane_info_t;

endpackage
`default_nettype wire

>>> hw/rtl/gnom_if.sv
// Request and response channel interfaces.
`default_nettype none
interface gnom_in_if;
  import gnom_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [TYPES_W-1:0]  cell_types;
  logic [QSEL_W-1:0]   quadrant_sel;
  logic [TYPE_W-1:0]   type_sel;
  modport source(output valid, action, pos_x, pos_y, cell_types, quadrant_sel, type_sel,
                 input ready);
  modport sink(input valid, action, pos_x, pos_y, cell_types, quadrant_sel, type_sel,
               output ready);
endinterface

interface gnom_out_if;
  import gnom_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [NBR-1:0]            new_mask;
  logic [COUNT_W-1:0]        count_value;
  logic signed [CELL_W-1:0]  cell_value;
  modport source(output valid, new_mask, count_value, cell_value, input ready);
  modport sink(input valid, new_mask, count_value, cell_value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/grid_neighbourhood_observation_map_core.sv
// Top level of the grid observation map with per-quadrant type histogram.
`default_nettype none
`include "assert_macros.svh"
// One transaction at a time. In an observe, nine lanes work out their neighbour
// addresses in parallel, then the map RAM is walked one lane per cycle, the 9 reads
// on its read port overlapped with write-backs on its separate write port. A count
// read registers the bin, then posts it; a cell read captures the map data, then posts it.
// A clear, and the pass after reset, sweeps all (GRID_W+2)*(GRID_H+2) map cells one
// per cycle (324 cells at the default size), during which no request is taken;
// world_mode writes are accepted at any time. A finished response sits in an output
// register, so the next request may start before it is taken.
module grid_neighbourhood_observation_map_core #(
  parameter int GRID_W        = gnom_pkg::DEF_GRID_W,
  parameter int GRID_H        = gnom_pkg::DEF_GRID_H,
  parameter int NUM_QUADRANTS = gnom_pkg::DEF_NUM_QUADRANTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [gnom_pkg::MODE_W-1:0] wr_data,
  gnom_in_if.sink                    req,
  gnom_out_if.source                 rsp
);
  import gnom_pkg::*;

  localparam int MAP_W = GRID_W + 2;
  localparam int MAP_H = GRID_H + 2;
  localparam int DEPTH = MAP_W * MAP_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int NCNT  = NUM_QUADRANTS * MAX_TYPES;
  localparam int CI_W  = $clog2(NCNT);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_OBS, S_CELL, S_FIN} state_t;

  state_t                   state;
  logic [MODE_W-1:0]        world_mode;
  logic [POS_W-1:0]         px, py;
  logic [TYPES_W-1:0]       types;
  logic                     sq_en, clr_report, cell_in_map;
  logic [NBR_IDX_W-1:0]     rd_idx, p_lane;
  logic                     rd_live, p_valid;
  logic [CRD_W-1:0]         cx, cy;
  logic [AW-1:0]            sw_addr;
  logic [NBR-1:0]           res_mask;
  logic [COUNT_W-1:0]       res_cnt;
  logic signed [CELL_W-1:0] res_cell;
  logic [COUNT_W-1:0]       counts [NCNT];

  logic [AW-1:0]            lane_addr [NBR];
  lane_info_t               lane_info [NBR];

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr, cell_addr;
  logic [CELL_W-1:0]        ram_wdata, ram_rdata;
  logic signed [CELL_W-1:0] sweep_val;
  logic                     accept, hit, cnt_inc, out_free;
  lane_info_t               p_info;
  logic [CI_W-1:0]          cnt_idx;
  logic [COUNT_W-1:0]       cnt_rd;

  // Neighbourhood lanes
  for (genvar k = 0; k < NBR; k++) begin : g_lane
    gnom_lane #(.GRID_W(GRID_W), .GRID_H(GRID_H), .K(k), .AW(AW)) u_lane (
      .pos_x (px),
      .pos_y (py),
      .ctype (types[TYPE_W*k +: TYPE_W]),
      .addr  (lane_addr[k]),
      .info  (lane_info[k])
    );
  end

  gnom_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign cell_addr = AW'(int'(req.pos_x) * MAP_H + int'(req.pos_y));

  // Merge side: lane whose map data is back this cycle
  assign p_info  = lane_info[p_lane];
  assign hit     = (state == S_OBS) && p_valid && p_info.in_map &&
                   ($signed(ram_rdata) == CELL_UNSEEN);
  assign cnt_idx = (state == S_OBS) ? CI_W'({p_info.quad, p_info.ctype})
                                    : CI_W'({req.quadrant_sel, req.type_sel});
  assign cnt_rd  = counts[cnt_idx];
  assign cnt_inc = hit && !p_info.border &&
                   ((world_mode != MODE_THREE) || (p_info.ctype < TYPES_IN_MODE_THREE)) &&
                   (cnt_rd != '1);

  // Value of a cleared cell
  always_comb begin
    if ((cx == '0) || (cy == '0) || (cx == CRD_W'(MAP_W - 1)) || (cy == CRD_W'(MAP_H - 1))) begin
      sweep_val = CELL_WALL;
    end else if (sq_en && (cx >= CRD_W'(SQ_LO)) && (cx < CRD_W'(SQ_HI)) &&
                 (cy >= CRD_W'(SQ_LO)) && (cy < CRD_W'(SQ_HI))) begin
      sweep_val = CELL_FLOOR;
    end else begin
      sweep_val = CELL_UNSEEN;
    end
  end

  // Map port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lane_addr[p_lane];
    ram_wdata = {1'b0, p_info.ctype};
    ram_raddr = lane_addr[rd_idx];
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sw_addr;
        ram_wdata = sweep_val;
      end
      S_OBS: begin
        ram_we = hit;
      end
      S_IDLE: begin
        ram_raddr = cell_addr;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, histogram and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      world_mode <= MODE_THREE;
      sq_en      <= 1'b0;
      clr_report <= 1'b0;
      cx         <= '0;
      cy         <= '0;
      sw_addr    <= '0;
      rd_live    <= 1'b0;
      p_valid    <= 1'b0;
      rsp.valid  <= 1'b0;
      for (int i = 0; i < NCNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        world_mode <= wr_data;
      end
      if (rsp.valid && rsp.ready && !((state == S_FIN) && out_free)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          sw_addr <= sw_addr + 1'b1;
          if (cy == CRD_W'(MAP_H - 1)) begin
            cy <= '0;
            cx <= cx + 1'b1;
          end else begin
            cy <= cy + 1'b1;
          end
          if (sw_addr == AW'(DEPTH - 1)) begin
            state <= clr_report ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            px       <= req.pos_x;
            py       <= req.pos_y;
            types    <= req.cell_types;
            res_mask <= '0;
            res_cnt  <= '0;
            res_cell <= CELL_FLOOR;
            case (action_t'(req.action))
              ACT_OBSERVE: begin
                rd_idx  <= NBR_IDX_W'(NBR - 1);
                rd_live <= 1'b1;
                p_valid <= 1'b0;
                state   <= S_OBS;
              end
              ACT_CLEAR: begin
                sq_en      <= (world_mode == MODE_SQUARE);
                clr_report <= 1'b1;
                cx         <= '0;
                cy         <= '0;
                sw_addr    <= '0;
                for (int i = 0; i < NCNT; i++) begin
                  counts[i] <= '0;
                end
                state <= S_CLR;
              end
              ACT_READ_COUNT: begin
                res_cnt <= cnt_rd;
                state   <= S_FIN;
              end
              ACT_READ_CELL: begin
                cell_in_map <= (CRD_W'(req.pos_x) < CRD_W'(MAP_W)) &&
                               (CRD_W'(req.pos_y) < CRD_W'(MAP_H));
                state       <= S_CELL;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_OBS: begin
          // issue side walks lanes 8 down to 0
          p_valid <= rd_live;
          p_lane  <= rd_idx;
          if (rd_live) begin
            if (rd_idx == '0) begin
              rd_live <= 1'b0;
            end else begin
              rd_idx <= rd_idx - 1'b1;
            end
          end
          // write-back side
          if (hit) begin
            res_mask[p_lane] <= 1'b1;
          end
          if (cnt_inc) begin
            counts[cnt_idx] <= cnt_rd + 1'b1;
          end
          if (!rd_live && p_valid) begin
            state <= S_FIN;
          end
        end
        S_CELL: begin
          res_cell <= cell_in_map ? $signed(ram_rdata) : CELL_WALL;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.new_mask    <= res_mask;
            rsp.count_value <= res_cnt;
            rsp.cell_value  <= res_cell;
            clr_report      <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_one_field_live, rsp.valid,
                  (rsp.new_mask == '0) || ((rsp.count_value == '0) && (rsp.cell_value == '0)))
  `ASSERT_IMPLIES(a_map_write_src, ram_we, (state == S_OBS) || (state == S_CLR))
  `ASSERT_NEXT(a_obs_drains, (state == S_OBS) && p_valid && !rd_live, state == S_FIN)
  `ASSERT_IMPLIES(a_cell_range, rsp.valid, rsp.cell_value >= CELL_UNSEEN)

endmodule
`default_nettype wire

>>> hw/rtl/gnom_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gnom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/gnom_lane.sv
// One neighbourhood lane: world coordinate, map address and histogram bin.
`default_nettype none
module gnom_lane #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16,
  parameter int K      = 0,
  parameter int AW     = 9
) (
  input  logic [gnom_pkg::POS_W-1:0]  pos_x,
  input  logic [gnom_pkg::POS_W-1:0]  pos_y,
  input  logic [gnom_pkg::TYPE_W-1:0] ctype,
  output logic [AW-1:0]               addr,
  output gnom_pkg::lane_info_t        info
);
  import gnom_pkg::*;

  localparam int MAP_W = GRID_W + 2;
  localparam int MAP_H = GRID_H + 2;

  logic [CRD_W-1:0] nx, ny;
  logic             in_map;

  // world = agent + 1 + offset, offsets stored pre-biased by one
  assign nx = CRD_W'(pos_x) + CRD_W'(NB_OFF_X[K]);
  assign ny = CRD_W'(pos_y) + CRD_W'(NB_OFF_Y[K]);
  assign in_map = (nx < CRD_W'(MAP_W)) && (ny < CRD_W'(MAP_H));

  assign addr = in_map ? AW'(int'(nx) * MAP_H + int'(ny)) : '0;

  assign info.in_map = in_map;
  assign info.border = (nx == '0) || (ny == '0) ||
                       (nx == CRD_W'(MAP_W - 1)) || (ny == CRD_W'(MAP_H - 1));
  assign info.quad   = {nx >= CRD_W'(GRID_W / 2 + 1), ny >= CRD_W'(GRID_H / 2 + 1)};
  assign info.ctype  = ctype;
endmodule
`default_nettype wire
